/* design/spfr_pkg.sv */
// ============================================================================
// spfr_pkg - shared definitions for the surface plane fit residual block
// Status and register codes, reset values, magnitude limits and the small
// index tables that drive the plane fit sequencer.
// ============================================================================
package spfr_pkg;

    localparam int NEIGHBORS_DEF = 5;
    localparam int CFG_IDX_W     = 2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FAR         = 2'd1;
    localparam logic [1:0] ST_NOT_PLANAR  = 2'd2;
    localparam logic [1:0] ST_DEGENERATE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SQ    = 2'd1;

    localparam logic KIND_NEIGHBOR = 1'b0;
    localparam logic KIND_QUERY    = 1'b1;

    localparam logic [31:0] PLANE_TOL_RST = 32'd13107;
    localparam logic [31:0] MAX_SQ_RST    = 32'd65536;

    localparam logic [63:0] MAG_A_LIM   = 64'h0000_0000_0008_0000;
    localparam logic [63:0] MAG_D_LIM   = 64'h0000_0000_4000_0000;
    localparam logic [63:0] NRM_ONE     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] OFF_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] OFF_NEG_MAX = 64'h0000_0000_8000_0000;
    localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;

    // normal matrix products: a00 a01 a02 a11 a12 a22
    localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_K [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // symmetric matrix element to storage slot, right hand side from C_BASE
    localparam logic [3:0] A_IDX [9] = '{4'd0, 4'd1, 4'd2,
                                         4'd1, 4'd3, 4'd4,
                                         4'd2, 4'd4, 4'd5};
    localparam logic [3:0] C_BASE = 4'd6;

    // cofactor columns for each first-row term of the determinant
    localparam logic [1:0] TERM_U [3] = '{2'd1, 2'd0, 2'd0};
    localparam logic [1:0] TERM_V [3] = '{2'd2, 2'd2, 2'd1};

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

/* design/surface_plane_fit_residual_top.sv */
// ============================================================================
// surface_plane_fit_residual_top - point to plane residual for one query
// Loads neighbor points, fits the plane w.x = -1 by least squares and
// reports the unit normal and the query offset, or a reject status.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall    kind, coord_x/y/z, far_sq_dist
//  out       source     o_out_valid / i_out_stall  status, normal_x/y/z, offset
//  cfg       sink       i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
//  A fitted query sends every product through one shared 33x33
//  multiplier; the square root runs 32 steps and each of the four
//  divisions 64 steps. Early rejects (too few neighbors, far query) go
//  straight to the done state. Synchronous active-low reset clears the
//  sequencer, the neighbor count and the output valid, and loads the
//  config registers with their reset values. The result sits in an output
//  register, so a stalled output holds only the next query at its end.
//
module surface_plane_fit_residual_top #(
    parameter int NEIGHBORS = spfr_pkg::NEIGHBORS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic signed [31:0]             i_coord_x,
    input  logic signed [31:0]             i_coord_y,
    input  logic signed [31:0]             i_coord_z,
    input  logic        [31:0]             i_far_sq_dist,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic        [1:0]              o_status,
    output logic signed [31:0]             o_normal_x,
    output logic signed [31:0]             o_normal_y,
    output logic signed [31:0]             o_normal_z,
    output logic signed [31:0]             o_residual_offset,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [31:0]             i_cfg_data
);

    localparam int IDX_W = $clog2(NEIGHBORS);
    localparam int CNT_W = $clog2(NEIGHBORS + 1);
    localparam int A_W   = 48 + $clog2(NEIGHBORS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEIGHBORS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NEIGHBORS);

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_ACC  = 16'b0000_0000_0000_0010,
        S_MAX1 = 16'b0000_0000_0000_0100,
        S_SHF1 = 16'b0000_0000_0000_1000,
        S_DET  = 16'b0000_0000_0001_0000,
        S_FOLD = 16'b0000_0000_0010_0000,
        S_MAX2 = 16'b0000_0000_0100_0000,
        S_SHF2 = 16'b0000_0000_1000_0000,
        S_NSQ  = 16'b0000_0001_0000_0000,
        S_SQRT = 16'b0000_0010_0000_0000,
        S_LIM  = 16'b0000_0100_0000_0000,
        S_CHK  = 16'b0000_1000_0000_0000,
        S_DSET = 16'b0001_0000_0000_0000,
        S_DIV  = 16'b0010_0000_0000_0000,
        S_OFF  = 16'b0100_0000_0000_0000,
        S_DONE = 16'b1000_0000_0000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [31:0]              r_tol, r_maxsq;
    logic signed [31:0]       r_sx [NEIGHBORS];
    logic signed [31:0]       r_sy [NEIGHBORS];
    logic signed [31:0]       r_sz [NEIGHBORS];

    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [2:0]               r_step, n_step;
    logic                     r_ph, n_ph;
    logic [1:0]               r_term, n_term;
    logic [1:0]               r_di, n_di;
    logic [1:0]               r_k, n_k;
    logic [5:0]               r_cnt, n_cnt;
    logic signed [A_W-1:0]    r_m [9];
    logic signed [A_W-1:0]    n_m [9];
    logic signed [63:0]       r_d [4];
    logic signed [63:0]       n_d [4];
    logic signed [63:0]       r_acc, n_acc;
    logic [63:0]              r_mx, n_mx;
    logic [63:0]              r_sv, n_sv;
    logic [63:0]              r_sr, n_sr;
    logic [63:0]              r_bit, n_bit;
    logic [63:0]              r_lim, n_lim;
    logic [63:0]              r_dq, n_dq;
    logic [31:0]              r_rem, n_rem;
    logic                     r_neg, n_neg;
    logic signed [31:0]       r_q [3];
    logic signed [31:0]       n_q [3];
    logic [1:0]               r_status, n_status;
    logic signed [31:0]       r_nrm [3];
    logic signed [31:0]       n_nrm [3];
    logic signed [31:0]       r_off, n_off;
    logic signed [65:0]       r_prod;

    logic                     r_ov, n_ov;
    logic [1:0]               r_o_status, n_o_status;
    logic signed [31:0]       r_o_nx, n_o_nx;
    logic signed [31:0]       r_o_ny, n_o_ny;
    logic signed [31:0]       r_o_nz, n_o_nz;
    logic signed [31:0]       r_o_off, n_o_off;

    logic                     in_acc;
    logic                     load_nb;
    logic signed [31:0]       pt [3];
    logic signed [32:0]       mul_a, mul_b;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign load_nb = in_acc && (i_kind == spfr_pkg::KIND_NEIGHBOR) && (r_count != FULL_CNT);

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_ov;
    assign o_status          = r_o_status;
    assign o_normal_x        = r_o_nx;
    assign o_normal_y        = r_o_ny;
    assign o_normal_z        = r_o_nz;
    assign o_residual_offset = r_o_off;

    always_comb begin
        pt[0] = (r_state == S_OFF) ? r_q[0] : r_sx[r_idx];
        pt[1] = (r_state == S_OFF) ? r_q[1] : r_sy[r_idx];
        pt[2] = (r_state == S_OFF) ? r_q[2] : r_sz[r_idx];
    end

    function automatic logic signed [19:0] elem(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] ix;
        ix = 4'(row) * 4'd3 + 4'(col);
        if (r_di != 2'd0 && col == r_di - 2'd1) begin
            return r_m[spfr_pkg::C_BASE + 4'(row)][19:0];
        end
        return r_m[spfr_pkg::A_IDX[ix]][19:0];
    endfunction

    always_comb begin
        logic signed [63:0] ext;
        logic [63:0]        mg;
        logic [63:0]        sq_try;
        logic signed [63:0] num;
        logic signed [63:0] prod64;
        logic [32:0]        rem_sh;
        logic [32:0]        den;
        logic               geq;
        logic [63:0]        q_nx;
        logic [31:0]        qmag;
        logic [1:0]         col_u;
        logic [1:0]         col_v;

        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_step   = r_step;
        n_ph     = r_ph;
        n_term   = r_term;
        n_di     = r_di;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_m      = r_m;
        n_d      = r_d;
        n_acc    = r_acc;
        n_mx     = r_mx;
        n_sv     = r_sv;
        n_sr     = r_sr;
        n_bit    = r_bit;
        n_lim    = r_lim;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_neg    = r_neg;
        n_q      = r_q;
        n_status = r_status;
        n_nrm    = r_nrm;
        n_off    = r_off;
        n_o_status = r_o_status;
        n_o_nx   = r_o_nx;
        n_o_ny   = r_o_ny;
        n_o_nz   = r_o_nz;
        n_o_off  = r_o_off;
        n_ov     = (r_ov && !i_out_stall) ? 1'b0 : r_ov;
        mul_a    = '0;
        mul_b    = '0;

        ext    = '0;
        mg     = '0;
        sq_try = r_sr + r_bit;
        num    = '0;
        prod64 = $signed(r_prod[63:0]);
        rem_sh = {r_rem, r_dq[63]};
        den    = {1'b0, r_sr[31:0]};
        geq    = (rem_sh >= den);
        q_nx   = {r_dq[62:0], geq};
        qmag   = '0;
        col_u  = spfr_pkg::TERM_U[r_term];
        col_v  = spfr_pkg::TERM_V[r_term];

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_kind == spfr_pkg::KIND_QUERY) begin
                    n_q[0]  = i_coord_x;
                    n_q[1]  = i_coord_y;
                    n_q[2]  = i_coord_z;
                    n_count = '0;
                    if (r_count != FULL_CNT) begin
                        n_status = spfr_pkg::ST_DEGENERATE;
                        n_state  = S_DONE;
                    end else if (i_far_sq_dist >= r_maxsq) begin
                        n_status = spfr_pkg::ST_FAR;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_ACC;
                        n_idx   = '0;
                        n_step  = '0;
                        n_ph    = 1'b0;
                        for (int i = 0; i < 9; i++) n_m[i] = '0;
                    end
                end else if (load_nb) begin
                    n_count = r_count + 1'b1;
                end
            end
            S_ACC: begin
                mul_a = 33'(pt[spfr_pkg::PAIR_J[r_step]]);
                mul_b = 33'(pt[spfr_pkg::PAIR_K[r_step]]);
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    n_m[4'(r_step)] = r_m[4'(r_step)] + $signed(r_prod[63:16]);
                    if (r_step == 3'd5) begin
                        n_step = '0;
                        n_m[6] = r_m[6] - pt[0];
                        n_m[7] = r_m[7] - pt[1];
                        n_m[8] = r_m[8] - pt[2];
                        if (r_idx == LAST_IDX) begin
                            n_state = S_MAX1;
                            n_mx    = '0;
                            n_cnt   = '0;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_MAX1: begin
                ext = 64'(r_m[r_cnt[3:0]]);
                mg  = spfr_pkg::mag64(ext);
                if (mg > r_mx) n_mx = mg;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd8) n_state = S_SHF1;
            end
            S_SHF1: begin
                if (r_mx >= spfr_pkg::MAG_A_LIM) begin
                    n_mx = r_mx >> 1;
                    for (int i = 0; i < 9; i++) n_m[i] = r_m[i] >>> 1;
                end else begin
                    n_state = S_DET;
                    n_di    = '0;
                    n_term  = '0;
                    n_step  = '0;
                    n_ph    = 1'b0;
                    for (int i = 0; i < 4; i++) n_d[i] = '0;
                end
            end
            S_DET: begin
                case (r_step)
                    3'd0: begin
                        mul_a = 33'(elem(2'd1, col_u));
                        mul_b = 33'(elem(2'd2, col_v));
                    end
                    3'd1: begin
                        mul_a = 33'(elem(2'd1, col_v));
                        mul_b = 33'(elem(2'd2, col_u));
                    end
                    3'd2: begin
                        mul_a = 33'(elem(2'd0, r_term));
                        mul_b = {1'b0, r_acc[31:0]};
                    end
                    default: begin
                        mul_a = 33'(elem(2'd0, r_term));
                        mul_b = {r_acc[63], r_acc[63:32]};
                    end
                endcase
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    case (r_step)
                        3'd0: n_acc = prod64;
                        3'd1: n_acc = r_acc - prod64;
                        3'd2: n_d[r_di] = (r_term == 2'd1) ? r_d[r_di] - prod64
                                                           : r_d[r_di] + prod64;
                        default: n_d[r_di] = (r_term == 2'd1)
                                           ? r_d[r_di] - $signed({r_prod[31:0], 32'd0})
                                           : r_d[r_di] + $signed({r_prod[31:0], 32'd0});
                    endcase
                    if (r_step == 3'd3) begin
                        n_step = '0;
                        if (r_term == 2'd2) begin
                            n_term = '0;
                            if (r_di == 2'd3) n_state = S_FOLD;
                            else n_di = r_di + 2'd1;
                        end else begin
                            n_term = r_term + 2'd1;
                        end
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_FOLD: begin
                if (r_d[0] == 64'sd0) begin
                    n_status = spfr_pkg::ST_DEGENERATE;
                    n_state  = S_DONE;
                end else begin
                    if (r_d[0][63]) begin
                        for (int i = 0; i < 4; i++) n_d[i] = -r_d[i];
                    end
                    n_state = S_MAX2;
                    n_mx    = '0;
                    n_cnt   = '0;
                end
            end
            S_MAX2: begin
                mg = spfr_pkg::mag64(r_d[r_cnt[1:0]]);
                if (mg > r_mx) n_mx = mg;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd3) n_state = S_SHF2;
            end
            S_SHF2: begin
                if (r_mx >= spfr_pkg::MAG_D_LIM) begin
                    n_mx = r_mx >> 1;
                    for (int i = 0; i < 4; i++) n_d[i] = r_d[i] >>> 1;
                end else begin
                    n_state = S_NSQ;
                    n_acc   = '0;
                    n_step  = '0;
                    n_ph    = 1'b0;
                end
            end
            S_NSQ: begin
                mul_a = $signed(r_d[2'(r_step) + 2'd1][32:0]);
                mul_b = $signed(r_d[2'(r_step) + 2'd1][32:0]);
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_acc = r_acc + prod64;
                    if (r_step == 3'd2) begin
                        n_state = S_SQRT;
                        n_sv    = 64'(r_acc + prod64);
                        n_sr    = '0;
                        n_bit   = spfr_pkg::SQRT_BIT0;
                        n_cnt   = '0;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            S_SQRT: begin
                if (r_sv >= sq_try) begin
                    n_sv = r_sv - sq_try;
                    n_sr = (r_sr >> 1) + r_bit;
                end else begin
                    n_sr = r_sr >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                n_ph  = 1'b0;
                if (r_cnt == 6'd31) n_state = S_LIM;
            end
            S_LIM: begin
                mul_a = {1'b0, r_tol};
                mul_b = {1'b0, r_sr[31:0]};
                if (!r_ph) begin
                    if (r_sr == 64'd0) begin
                        n_status = spfr_pkg::ST_DEGENERATE;
                        n_state  = S_DONE;
                    end else begin
                        n_ph = 1'b1;
                    end
                end else begin
                    n_ph    = 1'b0;
                    n_lim   = r_prod[63:0];
                    n_state = S_CHK;
                    n_idx   = '0;
                    n_step  = '0;
                end
            end
            S_CHK, S_OFF: begin
                if (r_step == 3'd0) begin
                    n_acc  = r_d[0] <<< 16;
                    n_step = 3'd1;
                end else if (r_step <= 3'd3) begin
                    mul_a = $signed(r_d[r_step[1:0]][32:0]);
                    mul_b = 33'(pt[2'(r_step - 3'd1)]);
                    if (!r_ph) begin
                        n_ph = 1'b1;
                    end else begin
                        n_ph   = 1'b0;
                        n_acc  = r_acc + prod64;
                        n_step = r_step + 3'd1;
                        if (r_state == S_OFF && r_step == 3'd3) begin
                            n_state = S_DSET;
                            n_k     = 2'd3;
                        end
                    end
                end else begin
                    if (spfr_pkg::mag64(r_acc) > r_lim) begin
                        n_status = spfr_pkg::ST_NOT_PLANAR;
                        n_state  = S_DONE;
                    end else if (r_idx == LAST_IDX) begin
                        n_state = S_DSET;
                        n_k     = '0;
                    end else begin
                        n_idx  = r_idx + 1'b1;
                        n_step = '0;
                    end
                end
            end
            S_DSET: begin
                if (r_k != 2'd3) num = r_d[r_k + 2'd1] <<< 30;
                else num = r_acc;
                n_neg   = num[63];
                n_dq    = spfr_pkg::mag64(num);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = geq ? 32'(rem_sh - den) : rem_sh[31:0];
                n_dq  = q_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    if (r_k == 2'd3) begin
                        if (r_neg) begin
                            n_off = (q_nx > spfr_pkg::OFF_POS_MAX)
                                  ? 32'(spfr_pkg::OFF_POS_MAX) : q_nx[31:0];
                        end else begin
                            n_off = (q_nx > spfr_pkg::OFF_NEG_MAX)
                                  ? 32'(spfr_pkg::OFF_NEG_MAX) : 32'd0 - q_nx[31:0];
                        end
                        n_status = spfr_pkg::ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        qmag = (q_nx > spfr_pkg::NRM_ONE) ? 32'(spfr_pkg::NRM_ONE) : q_nx[31:0];
                        n_nrm[r_k] = r_neg ? 32'd0 - qmag : qmag;
                        if (r_k == 2'd2) begin
                            n_state = S_OFF;
                            n_step  = '0;
                            n_ph    = 1'b0;
                        end else begin
                            n_k     = r_k + 2'd1;
                            n_state = S_DSET;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_state    = S_IDLE;
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    if (r_status == spfr_pkg::ST_OK) begin
                        n_o_nx  = r_nrm[0];
                        n_o_ny  = r_nrm[1];
                        n_o_nz  = r_nrm[2];
                        n_o_off = r_off;
                    end else begin
                        n_o_nx  = '0;
                        n_o_ny  = '0;
                        n_o_nz  = '0;
                        n_o_off = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_tol   <= spfr_pkg::PLANE_TOL_RST;
            r_maxsq <= spfr_pkg::MAX_SQ_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    spfr_pkg::CFG_PLANE_TOL: r_tol   <= i_cfg_data;
                    spfr_pkg::CFG_MAX_SQ:    r_maxsq <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_nb) begin
            r_sx[r_count[IDX_W-1:0]] <= i_coord_x;
            r_sy[r_count[IDX_W-1:0]] <= i_coord_y;
            r_sz[r_count[IDX_W-1:0]] <= i_coord_z;
        end
        r_prod     <= mul_a * mul_b;
        r_idx      <= n_idx;
        r_step     <= n_step;
        r_ph       <= n_ph;
        r_term     <= n_term;
        r_di       <= n_di;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_m        <= n_m;
        r_d        <= n_d;
        r_acc      <= n_acc;
        r_mx       <= n_mx;
        r_sv       <= n_sv;
        r_sr       <= n_sr;
        r_bit      <= n_bit;
        r_lim      <= n_lim;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_q        <= n_q;
        r_status   <= n_status;
        r_nrm      <= n_nrm;
        r_off      <= n_off;
        r_o_status <= n_o_status;
        r_o_nx     <= n_o_nx;
        r_o_ny     <= n_o_ny;
        r_o_nz     <= n_o_nz;
        r_o_off    <= n_o_off;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("neighbor count beyond set size");

    a_det_inputs_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DET) |-> (r_mx < spfr_pkg::MAG_A_LIM))
        else $error("matrix entries not scaled before determinant");

    a_d_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NSQ) |-> (r_mx < spfr_pkg::MAG_D_LIM))
        else $error("solution terms not scaled before norm");

    a_rem_below_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_sr[63:32] == 32'd0 && r_rem < r_sr[31:0]))
        else $error("division remainder out of range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != spfr_pkg::ST_OK) |->
        (o_normal_x == 32'sd0 && o_normal_y == 32'sd0 &&
         o_normal_z == 32'sd0 && o_residual_offset == 32'sd0))
        else $error("rejected result carries nonzero payload");

endmodule
